FILE: rtl/core/heat_colormap_frame_theme_defines.svh
// Assertion macros for the heat colormap frame theme block.
`ifndef HEAT_COLORMAP_FRAME_THEME_DEFINES_SVH
`define HEAT_COLORMAP_FRAME_THEME_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define HCFT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("hcft assertion failed");

`define HCFT_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

`else

`define HCFT_ASSERT(lbl, clk, rstn, prop)

`define HCFT_ASSERT_MSG(lbl, clk, rstn, prop, msg)

`endif

`endif

FILE: rtl/core/hcft_pkg.sv
// Shared constants, color tables and command type for the heat colormap block.
package hcft_pkg;

  localparam int TIP_W    = 11;
  localparam int TARGET_W = 10;
  localparam int DUTY_W   = 8;
  localparam int COLOR_W  = 16;
  localparam int PCT_W    = 7;
  localparam int THR_W    = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int CNT_W    = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FULL_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOT_TIP_THR     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAT_THR    = 2'd2;

  localparam logic [DUTY_W-1:0] DUTY_FS_RESET = 8'd255;
  localparam logic [THR_W-1:0]  HOT_TIP_RESET = 10'd55;
  localparam logic [THR_W-1:0]  OVERHEAT_RESET = 10'd440;

  // divider operation select
  localparam logic [1:0] SEL_PCT   = 2'd0;
  localparam logic [1:0] SEL_RED   = 2'd1;
  localparam logic [1:0] SEL_GREEN = 2'd2;
  localparam logic [1:0] SEL_BLUE  = 2'd3;

  localparam int NUM_W     = 15;
  localparam int DEN_W     = 8;
  localparam int DIV_STEPS = NUM_W;
  localparam int STEP_W    = 4;

  localparam logic [6:0] PCT_MAX = 7'd100;
  localparam logic [7:0] PCT_SCALE = 8'd100;

  function automatic logic [15:0] rgb565(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  localparam int NSTOPS = 6;

  localparam logic [8:0] STOP_TEMP [NSTOPS] = '{
    9'd40, 9'd130, 9'd210, 9'd290, 9'd350, 9'd430
  };

  localparam logic [15:0] STOP_COLOR [NSTOPS] = '{
    rgb565(8'd170, 8'd210, 8'd255), rgb565(8'd0, 8'd255, 8'd255),
    rgb565(8'd40, 8'd230, 8'd60),   rgb565(8'd255, 8'd225, 8'd0),
    rgb565(8'd255, 8'd140, 8'd0),   rgb565(8'd255, 8'd30, 8'd20)
  };

  localparam logic [15:0] COLOR_IDLE_COOL = rgb565(8'd220, 8'd232, 8'd255);
  localparam logic [15:0] COLOR_NO_TIP    = rgb565(8'd120, 8'd132, 8'd145);
  localparam logic [15:0] COLOR_FLASH     = rgb565(8'd255, 8'd255, 8'd255);

  localparam int FLASH_BIT = 3;

  typedef struct packed {
    logic       load;
    logic       div_init;
    logic       div_step;
    logic       div_store;
    logic [1:0] div_sel;
    logic       result_load;
  } ctl_cmd_t;

endpackage

FILE: rtl/core/hcft_if.sv
// Valid/ready channel interfaces for the input and result beats.
interface hcft_in_if;
  import hcft_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [TIP_W-1:0]    tip_temp;
  logic [TARGET_W-1:0]        target_temp;
  logic                       tip_missing;
  logic [DUTY_W-1:0]          heater_duty;

  modport source (output valid, output tip_temp, output target_temp,
                  output tip_missing, output heater_duty, input ready);
  modport sink (input valid, input tip_temp, input target_temp,
                input tip_missing, input heater_duty, output ready);
endinterface

interface hcft_out_if;
  import hcft_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] fg_color;
  logic               show_bar;
  logic [PCT_W-1:0]   heat_percent;

  modport source (output valid, output fg_color, output show_bar,
                  output heat_percent, input ready);
  modport sink (input valid, input fg_color, input show_bar,
                input heat_percent, output ready);
endinterface

FILE: rtl/core/hcft_ctrl.sv
// Sequencer: accepts a beat, runs four divider passes, hands the result out.
module hcft_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hcft_pkg::ctl_cmd_t  cmd_o
);
  import hcft_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_STORE = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [1:0]        op_q, op_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    step_d      = step_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.div_sel = op_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d       = SEL_PCT;
          state_d    = S_INIT;
        end
      end
      S_INIT: begin
        cmd_o.div_init = 1'b1;
        step_d         = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.div_store = 1'b1;
        if (op_q == SEL_BLUE) begin
          state_d = S_WRITE;
        end else begin
          op_d    = op_q + 1'b1;
          state_d = S_INIT;
        end
      end
      S_WRITE: begin
        // wait until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.result_load = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.result_load | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= SEL_PCT;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/core/hcft_datapath.sv
// Datapath: config registers, frame counter, stop lookup, serial divider, result.
module hcft_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  hcft_pkg::ctl_cmd_t                   cmd_i,
  input  logic signed [hcft_pkg::TIP_W-1:0]    tip_temp_i,
  input  logic [hcft_pkg::TARGET_W-1:0]        target_temp_i,
  input  logic                                 tip_missing_i,
  input  logic [hcft_pkg::DUTY_W-1:0]          heater_duty_i,
  input  logic                                 cfg_we_i,
  input  logic [hcft_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [hcft_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic [hcft_pkg::COLOR_W-1:0]         fg_color_o,
  output logic                                 show_bar_o,
  output logic [hcft_pkg::PCT_W-1:0]           heat_percent_o
);
  import hcft_pkg::*;

  // configuration
  logic [DUTY_W-1:0] duty_fs_q;
  logic [THR_W-1:0]  hot_thr_q, ovh_thr_q;
  logic [CNT_W-1:0]  frame_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_fs_q   <= DUTY_FS_RESET;
      hot_thr_q   <= HOT_TIP_RESET;
      ovh_thr_q   <= OVERHEAT_RESET;
      frame_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DUTY_FULL_SCALE: duty_fs_q <= cfg_data_i[DUTY_W-1:0];
          CFG_HOT_TIP_THR:     hot_thr_q <= cfg_data_i[THR_W-1:0];
          CFG_OVERHEAT_THR:    ovh_thr_q <= cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        frame_cnt_q <= frame_cnt_q + 1'b1;
      end
    end
  end

  // stop segment lookup on the incoming temperature
  logic       below, above;
  logic [2:0] seg_idx;
  logic [TIP_W-1:0] pos_full;
  logic [8:0] span_full;

  always_comb begin
    below   = tip_temp_i <= $signed({2'b00, STOP_TEMP[0]});
    above   = tip_temp_i >= $signed({2'b00, STOP_TEMP[NSTOPS-1]});
    seg_idx = 3'd1;
    for (int i = NSTOPS - 1; i >= 1; i--) begin
      if (tip_temp_i < $signed({2'b00, STOP_TEMP[i]})) begin
        seg_idx = 3'(i);
      end
    end
    pos_full  = tip_temp_i - $signed({2'b00, STOP_TEMP[seg_idx - 3'd1]});
    span_full = STOP_TEMP[seg_idx] - STOP_TEMP[seg_idx - 3'd1];
  end

  logic signed [TIP_W-1:0] tip_q;
  logic        target_nz_q, missing_q, mid_q;
  logic [DUTY_W-1:0] duty_q;
  logic [15:0] seg_lo_q, seg_hi_q, clamp_q;
  logic [6:0]  pos_q, span_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tip_q       <= tip_temp_i;
      target_nz_q <= |target_temp_i;
      missing_q   <= tip_missing_i;
      duty_q      <= heater_duty_i;
      mid_q       <= !below && !above;
      clamp_q     <= below ? STOP_COLOR[0] : STOP_COLOR[NSTOPS-1];
      seg_lo_q    <= STOP_COLOR[seg_idx - 3'd1];
      seg_hi_q    <= STOP_COLOR[seg_idx];
      pos_q       <= pos_full[6:0];
      span_q      <= span_full[6:0];
    end
  end

  // divider operand selection
  logic [5:0]       lo_c, hi_c;
  logic signed [6:0] delta;
  logic [5:0]       mag;
  logic [12:0]      prod;
  logic [NUM_W-1:0] op_num;
  logic [DEN_W-1:0] op_den;
  logic             op_neg;
  logic [NUM_W-1:0] pct_num;

  always_comb begin
    case (cmd_i.div_sel)
      SEL_RED: begin
        lo_c = {1'b0, seg_lo_q[15:11]};
        hi_c = {1'b0, seg_hi_q[15:11]};
      end
      SEL_GREEN: begin
        lo_c = seg_lo_q[10:5];
        hi_c = seg_hi_q[10:5];
      end
      default: begin
        lo_c = {1'b0, seg_lo_q[4:0]};
        hi_c = {1'b0, seg_hi_q[4:0]};
      end
    endcase
    delta   = $signed({1'b0, hi_c}) - $signed({1'b0, lo_c});
    mag     = delta[6] ? 6'(-delta) : delta[5:0];
    prod    = {7'd0, mag} * {6'd0, pos_q};
    pct_num = NUM_W'({7'd0, duty_q} * {7'd0, PCT_SCALE});
    if (cmd_i.div_sel == SEL_PCT) begin
      op_num = pct_num;
      op_den = (duty_fs_q == '0) ? DUTY_FS_RESET : duty_fs_q;
      op_neg = 1'b0;
    end else begin
      op_num = {2'b00, prod};
      op_den = {1'b0, span_q};
      op_neg = delta[6];
    end
  end

  // restoring divider, one quotient bit per cycle; quotient shifts into num_q
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic             neg_q;
  logic [DEN_W:0]   trial, diff;
  logic             ge;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      num_q <= op_num;
      rem_q <= '0;
      den_q <= op_den;
      neg_q <= op_neg;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  // store quotient of the finished pass
  logic [6:0] q7, chan;
  logic [PCT_W-1:0] pct_q;
  logic [4:0] r_q, b_q;
  logic [5:0] g_q;

  assign q7   = num_q[6:0];
  assign chan = {1'b0, lo_c} + (neg_q ? 7'(-q7) : q7);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_store) begin
      case (cmd_i.div_sel)
        SEL_PCT:   pct_q <= (num_q > NUM_W'(PCT_MAX)) ? PCT_MAX : num_q[PCT_W-1:0];
        SEL_RED:   r_q   <= chan[4:0];
        SEL_GREEN: g_q   <= chan[5:0];
        default:   b_q   <= chan[4:0];
      endcase
    end
  end

  // final color selection
  logic [15:0] heat_col, fg_d;
  logic        hot, over, bar_d;

  always_comb begin
    heat_col = mid_q ? {r_q, g_q, b_q} : clamp_q;
    hot      = tip_q > $signed({1'b0, hot_thr_q});
    over     = tip_q >= $signed({1'b0, ovh_thr_q});
    bar_d    = !missing_q && target_nz_q;
    if (missing_q) begin
      fg_d = COLOR_NO_TIP;
    end else if (target_nz_q) begin
      fg_d = (over && frame_cnt_q[FLASH_BIT]) ? COLOR_FLASH : heat_col;
    end else if (hot) begin
      fg_d = heat_col;
    end else begin
      fg_d = COLOR_IDLE_COOL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      fg_color_o     <= fg_d;
      show_bar_o     <= bar_d;
      heat_percent_o <= bar_d ? pct_q : '0;
    end
  end

endmodule

FILE: rtl/core/heat_colormap_frame_theme.sv
// Top level of the heat colormap frame theme block.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        tip_temp, target_temp, tip_missing, heater_duty
//   out_ch   out  valid/ready        fg_color, show_bar, heat_percent
//   cfg      in   cfg_we_i (no wait) cfg_index_i, cfg_data_i
//
// Each item runs through the input load, four passes of the shared 15-step
// restoring divider (init, steps and store per pass: percent, then red,
// green, blue), and the output load. A new input beat is taken the cycle
// after the result is loaded, while that result may still wait in the output
// register. A stalled output holds the finished item in the write state.
// Reset clears the sequencer, frame counter and config registers to defaults.
module heat_colormap_frame_theme (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  hcft_in_if.sink                           in_ch,
  hcft_out_if.source                        out_ch,
  input  logic                              cfg_we_i,
  input  logic [hcft_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [hcft_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import hcft_pkg::*;
  `include "heat_colormap_frame_theme_defines.svh"

  ctl_cmd_t cmd;

  hcft_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .cmd_o       (cmd)
  );

  hcft_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .tip_temp_i     (in_ch.tip_temp),
    .target_temp_i  (in_ch.target_temp),
    .tip_missing_i  (in_ch.tip_missing),
    .heater_duty_i  (in_ch.heater_duty),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fg_color_o     (out_ch.fg_color),
    .show_bar_o     (out_ch.show_bar),
    .heat_percent_o (out_ch.heat_percent)
  );

  `HCFT_ASSERT(a_pct_range, clk_i, rst_ni, out_ch.valid |-> out_ch.heat_percent <= PCT_MAX)
  `HCFT_ASSERT(a_pct_zero_no_bar, clk_i, rst_ni, (out_ch.valid && !out_ch.show_bar) |-> out_ch.heat_percent == '0)
  `HCFT_ASSERT_MSG(a_one_in_flight, clk_i, rst_ni, cmd.load |=> !in_ch.ready, "input taken while busy")
  `HCFT_ASSERT_MSG(a_no_overwrite, clk_i, rst_ni, cmd.result_load |-> (!out_ch.valid || out_ch.ready), "pending result overwritten")

endmodule
